// File: src/three_wire_bus_receiver_core_assert.svh
// assertion macros for the three-wire bus receiver
`ifndef THREE_WIRE_BUS_RECEIVER_CORE_ASSERT_SVH
`define THREE_WIRE_BUS_RECEIVER_CORE_ASSERT_SVH

// same-cycle implication under reset
`define TWBR_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("three_wire_bus_receiver_core: assertion failed");

// next-cycle implication under reset
`define TWBR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("three_wire_bus_receiver_core: assertion failed");

`endif

// File: src/twbr_pkg.sv
// shared types and constants of the three-wire bus receiver
package twbr_pkg;

    localparam int BUF_BYTES_DEFAULT = 64;
    localparam int IDX_W             = 6;
    localparam int MLEN_W            = 7;
    localparam int ADDR_W            = 3;
    localparam int DATA_W            = 32;

    localparam int REG_OWN_ADDRESS = 0;
    localparam int REG_MASTER_MODE = 1;

    typedef enum logic [2:0] {
        EV_NONE    = 3'd0,
        EV_START   = 3'd1,
        EV_BIT     = 3'd2,
        EV_BYTE    = 3'd3,
        EV_DONE    = 3'd4,
        EV_REJECT  = 3'd5,
        EV_IGNORED = 3'd6,
        EV_ACK     = 3'd7
    } event_code_t;

    typedef enum logic [1:0] {
        TYPE_READ      = 2'd0,
        TYPE_WRITE     = 2'd1,
        TYPE_BROADCAST = 2'd2,
        TYPE_ERROR     = 2'd3
    } msg_type_t;

    typedef struct packed {
        logic kind;
        logic data_line;
        logic clk_line;
        logic busy_line;
    } item_t;

    typedef struct packed {
        event_code_t        event_code;
        msg_type_t          message_type;
        logic [7:0]         byte_value;
        logic [IDX_W-1:0]   byte_index;
        logic [MLEN_W-1:0]  message_length;
        logic [7:0]         source_address;
        logic               in_progress;
        logic               new_message;
    } result_t;

    typedef struct packed {
        logic [7:0] own_address;
        logic       master_mode;
    } cfg_t;

endpackage

// File: src/twbr_chan_if.sv
// valid/ready channel carrying one payload per transaction
interface twbr_chan_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

// File: src/three_wire_bus_receiver_core.sv
// top level of the three-wire bus receiver: channels, register port, pipeline
// usage:
//   item channel: one transaction per sampled line event (kind 0) or
//   software acknowledge (kind 1); result channel: exactly one transaction
//   per item, in order, with the event code and message status.
//   own_address at byte 0x0 and master_mode at byte 0x4 on the apb port;
//   write them only while no item is in flight.
// path: an item taken is held in the input register, then moves to the
//   result register, where it waits until it is taken.
// throughput: one item per cycle when not stalled; receiver state updates once
//   per item in a single pass from the input register to the result register.
// reset: rst_n low clears the pipeline, the receiver returns to idle with no
//   pending message and both registers read zero.
// stall: while result.ready is low the result register holds, the input
//   register takes one more item and item.ready then drops until the
//   result is taken.
module three_wire_bus_receiver_core
    import twbr_pkg::*;
#(
    parameter int BUF_BYTES = BUF_BYTES_DEFAULT
) (
    input  logic              clk,
    input  logic              rst_n,
    twbr_chan_if.sink         item,
    twbr_chan_if.source       result,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready
);

    localparam int IDX_LO = 2;

    cfg_t    cfg_reg;
    logic    stage_valid_reg;
    item_t   stage_item_reg;
    logic    result_valid_reg;
    result_t result_reg;
    result_t step_res;
    logic    advance;
    logic    cfg_write;
    logic    [ADDR_W-IDX_LO-1:0] reg_index;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign reg_index = paddr[ADDR_W-1:IDX_LO];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_write)
        begin
            case (reg_index)
                (ADDR_W-IDX_LO)'(REG_OWN_ADDRESS): cfg_reg.own_address <= pwdata[7:0];
                (ADDR_W-IDX_LO)'(REG_MASTER_MODE): cfg_reg.master_mode <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_index)
            (ADDR_W-IDX_LO)'(REG_OWN_ADDRESS): prdata = DATA_W'(cfg_reg.own_address);
            (ADDR_W-IDX_LO)'(REG_MASTER_MODE): prdata = DATA_W'(cfg_reg.master_mode);
            default: prdata = '0;
        endcase
    end

    assign advance    = stage_valid_reg && (!result_valid_reg || result.ready);
    assign item.ready = !stage_valid_reg || advance;

    twbr_engine #(
        .BUF_BYTES (BUF_BYTES)
    ) u_engine (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .item    (stage_item_reg),
        .cfg     (cfg_reg),
        .res     (step_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg  <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            stage_valid_reg  <= (item.valid && item.ready) || (stage_valid_reg && !advance);
            result_valid_reg <= advance || (result_valid_reg && !result.ready);
        end
    end

    always_ff @(posedge clk)
    begin
        if (item.valid && item.ready)
        begin
            stage_item_reg <= item.payload;
        end
        if (advance)
        begin
            result_reg <= step_res;
        end
    end

    assign result.valid   = result_valid_reg;
    assign result.payload = result_reg;

    `include "three_wire_bus_receiver_core_assert.svh"

    `TWBR_ASSERT_IMPLY(a_not_both_busy_and_pending, clk, rst_n,
        result.valid, !(result.payload.in_progress && result.payload.new_message))
    `TWBR_ASSERT_IMPLY(a_done_leaves_pending, clk, rst_n,
        result.valid && result.payload.event_code == EV_DONE,
        !result.payload.in_progress && result.payload.new_message)
    `TWBR_ASSERT_IMPLY(a_reject_drops_all, clk, rst_n,
        result.valid && result.payload.event_code == EV_REJECT,
        !result.payload.in_progress && !result.payload.new_message)
    `TWBR_ASSERT_IMPLY(a_full_stage_moves_on_take, clk, rst_n,
        item.valid && item.ready && stage_valid_reg, advance)
    `TWBR_ASSERT_NEXT(a_result_from_advance, clk, rst_n,
        !result_valid_reg && !advance, !result.valid)

endmodule

// File: src/twbr_engine.sv
// receiver state and per-event decode, one event per advance
module twbr_engine
    import twbr_pkg::*;
#(
    parameter int BUF_BYTES = BUF_BYTES_DEFAULT
) (
    input  logic    clk,
    input  logic    rst_n,
    input  logic    advance,
    input  item_t   item,
    input  cfg_t    cfg,
    output result_t res
);

    localparam int CNT_W = $clog2(BUF_BYTES + 1);
    localparam logic [CNT_W-1:0] BUF_CNT  = CNT_W'(BUF_BYTES);
    localparam logic [CNT_W-1:0] BUF_LAST = CNT_W'(BUF_BYTES - 1);

    logic             receiving_reg, receiving_next;
    logic             pending_reg, pending_next;
    msg_type_t        type_reg, type_next;
    logic [7:0]       shift_byte_reg, shift_byte_next;
    logic [2:0]       bit_pos_reg, bit_pos_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             checked_reg, checked_next;
    logic [7:0]       first_byte_reg, first_byte_next;

    logic             start_ok;
    logic [7:0]       shifted;
    logic [CNT_W-1:0] byte_slot;

    always_comb
    begin
        shifted = shift_byte_reg;
        shifted[bit_pos_reg] = item.data_line;
        byte_slot = (count_reg < BUF_CNT) ? count_reg : BUF_LAST;
    end

    always_comb
    begin
        receiving_next  = receiving_reg;
        pending_next    = pending_reg;
        type_next       = type_reg;
        shift_byte_next = shift_byte_reg;
        bit_pos_next    = bit_pos_reg;
        count_next      = count_reg;
        checked_next    = checked_reg;
        first_byte_next = first_byte_reg;
        start_ok        = 1'b0;
        res             = '0;
        res.event_code  = EV_NONE;

        if (item.kind)
        begin
            pending_next   = 1'b0;
            res.event_code = EV_ACK;
        end
        else if (!receiving_reg)
        begin
            if (!item.busy_line)
            begin
                if (!item.clk_line)
                begin
                    type_next = item.data_line ? TYPE_WRITE : TYPE_READ;
                    start_ok  = 1'b1;
                end
                else if (!item.data_line)
                begin
                    type_next = TYPE_BROADCAST;
                    start_ok  = cfg.master_mode;
                end
                else
                begin
                    type_next = TYPE_ERROR;
                end
                if (start_ok)
                begin
                    receiving_next  = 1'b1;
                    pending_next    = 1'b0;
                    count_next      = '0;
                    bit_pos_next    = 3'd7;
                    checked_next    = 1'b0;
                    first_byte_next = '0;
                    res.event_code  = EV_START;
                end
                else
                begin
                    res.event_code = EV_IGNORED;
                end
            end
        end
        else if (!item.busy_line)
        begin
            shift_byte_next = shifted;
            if (bit_pos_reg == 3'd0)
            begin
                bit_pos_next   = 3'd7;
                res.byte_value = shifted;
                res.byte_index = IDX_W'(byte_slot);
                if (count_reg == '0)
                begin
                    first_byte_next = shifted;
                end
                if (count_reg < BUF_CNT)
                begin
                    count_next = count_reg + CNT_W'(1);
                end
                res.event_code = EV_BYTE;
                if (!checked_reg && !cfg.master_mode)
                begin
                    if (first_byte_next == cfg.own_address)
                    begin
                        checked_next = 1'b1;
                    end
                    else
                    begin
                        receiving_next = 1'b0;
                        pending_next   = 1'b0;
                        res.event_code = EV_REJECT;
                    end
                end
            end
            else
            begin
                bit_pos_next   = bit_pos_reg - 3'd1;
                res.event_code = EV_BIT;
            end
        end
        else
        begin
            receiving_next     = 1'b0;
            pending_next       = 1'b1;
            res.message_length = MLEN_W'(count_reg);
            res.source_address = first_byte_reg;
            res.event_code     = EV_DONE;
        end

        res.message_type = type_next;
        res.in_progress  = receiving_next;
        res.new_message  = pending_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            receiving_reg  <= 1'b0;
            pending_reg    <= 1'b0;
            type_reg       <= TYPE_READ;
            shift_byte_reg <= '0;
            bit_pos_reg    <= 3'd7;
            count_reg      <= '0;
            checked_reg    <= 1'b0;
            first_byte_reg <= '0;
        end
        else if (advance)
        begin
            receiving_reg  <= receiving_next;
            pending_reg    <= pending_next;
            type_reg       <= type_next;
            shift_byte_reg <= shift_byte_next;
            bit_pos_reg    <= bit_pos_next;
            count_reg      <= count_next;
            checked_reg    <= checked_next;
            first_byte_reg <= first_byte_next;
        end
    end

endmodule
